@@ hw/rtl/sfc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the CRC32 byte update for the segment frame checker.
// No dependencies.
package sfc_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int TAIL_BYTES   = 4;
    localparam int HCRC_SPAN    = 8;
    localparam int MAX_PAYLOAD  = 512;
    localparam int COUNT_W      = 10;
    localparam int RESULT_DEPTH = 4;
    localparam int PTR_W        = $clog2(RESULT_DEPTH);
    localparam int LEVEL_W      = $clog2(RESULT_DEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [31:0]        CRC_POLY  = 32'hEDB88320;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SIZE      = 3'd1,
        ST_TRUNCATED = 3'd2,
        ST_LENGTH    = 3'd3,
        ST_CRC       = 3'd4,
        ST_TYPE      = 3'd5
    } status_t;

    typedef struct packed {
        logic                 frame_end;
        logic [7:0]           payload_byte;
        logic [2:0]           frame_status;
        logic [1:0]           packet_type;
        logic [4:0]           window_size;
        logic [7:0]           sequence_number;
        logic [COUNT_W-1:0]   payload_length;
        logic [31:0]          time_stamp;
        logic [31:0]          payload_crc;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
        end
        return x;
    endfunction

endpackage

@@ hw/rtl/segment_frame_checker.sv @@
`timescale 1ns / 1ps
// Top level of the segment frame checker: parser feeding a small result queue.
// Depends on sfc_pkg, sfc_parser and sfc_result_fifo.
//
//  Channel | Direction | Beat contents
//  s_      | in        | tdata: data_byte; tlast: last_byte
//  m_      | out       | tdata: payload byte or frame status fields; tlast: frame_end
//
// One byte per cycle while the queue has room; results go from the input register into the queue.
// The final byte of a frame with a payload queues two results, so the queue absorbs one extra beat.
// s_tready drops while the input register is full and the queue has fewer than two free slots.
// aresetn clears the frame state and empties the queue; frame state also clears after each
// final byte.
module segment_frame_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] data_byte
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,   // [7:0] payload_byte, [10:8] frame_status,
                                     // [12:11] packet_type, [17:13] window_size,
                                     // [25:18] sequence_number, [35:26] payload_length,
                                     // [67:36] time_stamp, [99:68] payload_crc, rest zero
    output logic          m_tlast
);
    import sfc_pkg::*;

    push_t                push;
    logic                 space_ok;
    result_t              head;
    logic [LEVEL_W-1:0]   level;

    sfc_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .space_ok (space_ok),
        .push     (push)
    );

    sfc_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head),
        .level     (level)
    );

    assign m_tlast = head.frame_end;
    assign m_tdata = {4'd0, head.payload_crc, head.time_stamp, head.payload_length,
                      head.sequence_number, head.window_size, head.packet_type,
                      head.frame_status, head.payload_byte};

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= LEVEL_W'(RESULT_DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> level <= LEVEL_W'(RESULT_DEPTH - 2))
        else $error("results pushed without room");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[7:0] == 8'd0)
        else $error("status beat carries a payload byte");

    a_byte_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[103:8] == '0)
        else $error("payload beat carries status fields");

endmodule

@@ hw/rtl/sfc_parser.sv @@
`timescale 1ns / 1ps
// Input beat register, header capture, tail delay line, CRC checks and frame status.
// Depends on sfc_pkg.
module sfc_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    input  logic          space_ok,
    output sfc_pkg::push_t push
);
    import sfc_pkg::*;

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic                fire;

    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [7:0]          hb0_reg, hb0_next;
    logic [7:0]          seq_reg, seq_next;
    logic [15:0]         length_reg, length_next;
    logic [31:0]         stamp_reg, stamp_next;
    logic [31:0]         hcrc_rx_reg, hcrc_rx_next;
    logic [31:0]         hcrc_reg, hcrc_next;
    logic [31:0]         pcrc_reg, pcrc_next;
    logic [7:0]          tail_reg [TAIL_BYTES];
    logic [7:0]          tail_next [TAIL_BYTES];

    logic [COUNT_W-1:0]  psize;
    logic [31:0]         tail_crc;
    status_t             status;
    result_t             byte_res, status_res;
    logic                byte_out;

    assign fire     = in_valid_reg && space_ok;
    assign in_ready = !in_valid_reg || space_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    always_comb begin
        count_next   = count_reg;
        hb0_next     = hb0_reg;
        seq_next     = seq_reg;
        length_next  = length_reg;
        stamp_next   = stamp_reg;
        hcrc_rx_next = hcrc_rx_reg;
        hcrc_next    = hcrc_reg;
        pcrc_next    = pcrc_reg;
        tail_next    = tail_reg;
        byte_out     = 1'b0;
        if (count_reg < COUNT_W'(HEADER_BYTES)) begin
            if (count_reg < COUNT_W'(HCRC_SPAN)) begin
                hcrc_next = crc32_byte(hcrc_reg, in_byte_reg);
            end
            if (count_reg == '0) begin
                hb0_next = in_byte_reg;
            end else if (count_reg == COUNT_W'(1)) begin
                seq_next = in_byte_reg;
            end else if (count_reg < COUNT_W'(4)) begin
                length_next = {length_reg[7:0], in_byte_reg};
            end else if (count_reg < COUNT_W'(HCRC_SPAN)) begin
                stamp_next[8*count_reg[1:0] +: 8] = in_byte_reg;
            end else begin
                hcrc_rx_next = {hcrc_rx_reg[23:0], in_byte_reg};
            end
        end else begin
            for (int i = 0; i < TAIL_BYTES - 1; i++) begin
                tail_next[i] = tail_reg[i+1];
            end
            tail_next[TAIL_BYTES-1] = in_byte_reg;
            if (count_reg >= COUNT_W'(HEADER_BYTES + TAIL_BYTES)) begin
                pcrc_next = crc32_byte(pcrc_reg, tail_reg[0]);
                byte_out  = 1'b1;
            end
        end
        if (count_reg != COUNT_MAX) begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    assign tail_crc = {tail_next[0], tail_next[1], tail_next[2], tail_next[3]};
    assign psize    = (count_next > COUNT_W'(HEADER_BYTES + TAIL_BYTES))
                    ? count_next - COUNT_W'(HEADER_BYTES + TAIL_BYTES) : '0;

    always_comb begin
        priority if (count_next < COUNT_W'(HEADER_BYTES)
                     || (count_next > COUNT_W'(HEADER_BYTES) && psize == '0)) begin
            status = ST_SIZE;
        end else if (hb0_next[5]) begin
            status = ST_TRUNCATED;
        end else if (length_next > 16'(MAX_PAYLOAD)) begin
            status = ST_LENGTH;
        end else if (~hcrc_next != hcrc_rx_next) begin
            status = ST_CRC;
        end else if ({{(16-COUNT_W){1'b0}}, psize} != length_next) begin
            status = ST_LENGTH;
        end else if (hb0_next[7:6] == 2'd0) begin
            status = ST_TYPE;
        end else if (psize != '0 && ~pcrc_next != tail_crc) begin
            status = ST_CRC;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        byte_res              = '0;
        byte_res.payload_byte = tail_reg[0];

        status_res                 = '0;
        status_res.frame_end       = 1'b1;
        status_res.frame_status    = status;
        status_res.packet_type     = hb0_next[7:6];
        status_res.window_size     = hb0_next[4:0];
        status_res.sequence_number = seq_next;
        status_res.payload_length  = (length_next > 16'(COUNT_MAX))
                                   ? COUNT_MAX : length_next[COUNT_W-1:0];
        status_res.time_stamp      = stamp_next;
        status_res.payload_crc     = (psize != '0) ? tail_crc : 32'd0;

        push        = '0;
        push.second = status_res;
        if (fire) begin
            if (byte_out) begin
                push.first = byte_res;
                push.count = in_last_reg ? 2'd2 : 2'd1;
            end else if (in_last_reg) begin
                push.first = status_res;
                push.count = 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && in_last_reg)) begin
            count_reg   <= '0;
            hb0_reg     <= '0;
            seq_reg     <= '0;
            length_reg  <= '0;
            stamp_reg   <= '0;
            hcrc_rx_reg <= '0;
            hcrc_reg    <= '1;
            pcrc_reg    <= '1;
            for (int i = 0; i < TAIL_BYTES; i++) begin
                tail_reg[i] <= '0;
            end
        end else if (fire) begin
            count_reg   <= count_next;
            hb0_reg     <= hb0_next;
            seq_reg     <= seq_next;
            length_reg  <= length_next;
            stamp_reg   <= stamp_next;
            hcrc_rx_reg <= hcrc_rx_next;
            hcrc_reg    <= hcrc_next;
            pcrc_reg    <= pcrc_next;
            tail_reg    <= tail_next;
        end
    end

endmodule

@@ hw/rtl/sfc_result_fifo.sv @@
`timescale 1ns / 1ps
// Result queue taking up to two results per cycle and giving one per beat.
// Depends on sfc_pkg.
module sfc_result_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sfc_pkg::push_t          push,
    output logic                    space_ok,
    output logic                    out_valid,
    input  logic                    out_ready,
    output sfc_pkg::result_t        out_data,
    output logic [sfc_pkg::LEVEL_W-1:0] level
);
    import sfc_pkg::*;

    result_t              mem [RESULT_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic                 pop;

    assign out_valid = level_reg != '0;
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign space_ok  = level_reg <= LEVEL_W'(RESULT_DEPTH - 2);
    assign level     = level_reg;

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            level_reg  <= level_reg + LEVEL_W'(push.count) - LEVEL_W'(pop);
        end
    end

endmodule
